### hdl/tmdq_pkg.sv
// Shared constants, request codes and channel structs of the timed message display queue.
package tmdq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int WORD_BITS   = 32;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam int REQ_BITS    = 3;
    localparam int SHOWN_BITS  = 32;
    localparam int SEC_BITS    = 8;
    localparam int SUB_BITS    = 16;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    // Request codes
    localparam logic [REQ_BITS-1:0] REQ_TICK    = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_ENQUEUE = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_FORCE   = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_ADVANCE = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_READ    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DISPLAY_SECONDS  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TICKS_PER_SECOND = 1'd1;

    localparam logic [SEC_BITS-1:0] DISPLAY_SECONDS_RESET  = 8'd5;
    localparam logic [SUB_BITS-1:0] TICKS_PER_SECOND_RESET = 16'd100;

    typedef struct packed {
        logic [SEC_BITS-1:0] display_seconds;
        logic [SUB_BITS-1:0] ticks_per_second;
    } tmdq_cfg_t;

    typedef struct packed {
        logic [SHOWN_BITS-1:0] shown_word;
        logic                  showing;
        logic                  unread;
        logic [3:0]            queued;
    } tmdq_status_t;

endpackage

### hdl/tmdq_core.sv
// Queue store, display slot and timeout counters, updated by one request per step.
module tmdq_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             step_en,
    input  logic [tmdq_pkg::REQ_BITS-1:0]    req_type,
    input  logic [31:0]                      message_word,
    input  tmdq_pkg::tmdq_cfg_t              cfg,
    output tmdq_pkg::tmdq_status_t           status
);
    import tmdq_pkg::*;

    logic [WORD_BITS-1:0] store_mem [QUEUE_DEPTH];

    logic [PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]  fill_reg, fill_next;
    logic [WORD_BITS-1:0] slot_reg, slot_next;
    logic                 active_reg, active_next;
    logic                 unread_reg, unread_next;
    logic [SUB_BITS-1:0]  sub_reg, sub_next;
    logic [SEC_BITS-1:0]  sec_reg, sec_next;

    logic [WORD_BITS-1:0] word_in;
    logic [WORD_BITS-1:0] head_word;
    logic [SUB_BITS-1:0]  sub_inc;
    logic [SEC_BITS-1:0]  sec_inc;
    logic                 store_wr;
    logic                 full;

    assign word_in   = WORD_BITS'(message_word);
    assign head_word = store_mem[rd_ptr_reg];
    assign sub_inc   = sub_reg + 1'b1;
    assign sec_inc   = sec_reg + 1'b1;
    assign full      = (fill_reg == CNT_BITS'(QUEUE_DEPTH));

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // Apply one request to the state
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        slot_next   = slot_reg;
        active_next = active_reg;
        unread_next = unread_reg;
        sub_next    = sub_reg;
        sec_next    = sec_reg;
        store_wr    = 1'b0;
        if (step_en) begin
            case (req_type)
                REQ_TICK: begin
                    if (active_reg) begin
                        sub_next = sub_inc;
                        if (sub_inc > cfg.ticks_per_second) begin
                            sub_next = '0;
                            sec_next = sec_inc;
                            // timeout: clear the slot and flag the change
                            if (sec_inc > cfg.display_seconds) begin
                                sec_next    = '0;
                                active_next = 1'b0;
                                slot_next   = '0;
                                unread_next = 1'b1;
                            end
                        end
                    end
                end
                REQ_ENQUEUE: begin
                    // full queue: evict the oldest word onto the display
                    if (full) begin
                        slot_next   = head_word;
                        active_next = 1'b1;
                        unread_next = 1'b1;
                        sub_next    = '0;
                        sec_next    = '0;
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                    end else begin
                        fill_next = fill_reg + 1'b1;
                    end
                    store_wr    = 1'b1;
                    wr_ptr_next = ptr_inc(wr_ptr_reg);
                end
                REQ_FORCE: begin
                    slot_next   = word_in;
                    active_next = 1'b1;
                    unread_next = 1'b1;
                    sub_next    = '0;
                    sec_next    = '0;
                end
                REQ_ADVANCE: begin
                    // move the head to an idle display, timer untouched
                    if (fill_reg != '0 && !active_reg) begin
                        slot_next   = head_word;
                        active_next = 1'b1;
                        unread_next = 1'b1;
                        fill_next   = fill_reg - 1'b1;
                        rd_ptr_next = ptr_inc(rd_ptr_reg);
                    end
                end
                REQ_READ: begin
                    unread_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            slot_reg   <= '0;
            active_reg <= 1'b0;
            unread_reg <= 1'b0;
            sub_reg    <= '0;
            sec_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            slot_reg   <= slot_next;
            active_reg <= active_next;
            unread_reg <= unread_next;
            sub_reg    <= sub_next;
            sec_reg    <= sec_next;
        end
    end

    // Write the queue store
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[wr_ptr_reg] <= word_in;
        end
    end

    assign status.shown_word = SHOWN_BITS'(slot_reg);
    assign status.showing    = active_reg;
    assign status.unread     = unread_reg;
    assign status.queued     = 4'(fill_reg);

    // Fill count never passes the queue depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("fill count beyond queue depth");

    // An idle display holds the empty word
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> slot_reg == '0)
        else $error("idle display holds a word");

    // Force shows the word and marks it unread
    a_force_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && req_type == REQ_FORCE |=> active_reg && unread_reg && sub_reg == '0)
        else $error("force did not show the word");

    // Read clears the unread mark
    a_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && req_type == REQ_READ |=> !unread_reg)
        else $error("read left the unread mark");

    // An empty queue has equal pointers
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("empty queue with split pointers");

endmodule

### hdl/timed_message_display_queue_unit.sv
// Top level of the timed message display queue: input register, config registers, result beat.
//
//  channel | direction | handshake            | payload
//  s_      | in        | s_valid / s_ready     | s_req_type, s_message_word
//  m_      | out       | m_valid / m_ready     | m_shown_word, m_showing, m_unread, m_queued
//  cfg_    | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat per cycle sustained while m_ready allows; an s_ beat passes the input register,
// then the state update into the status registers that drive m_.
// The step stalls while a result beat waits on m_ready; the input register
// then holds one beat and s_ready drops. Config beats are always taken.
// Synchronous active-low reset clears all control state; no clearing pass.
module timed_message_display_queue_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [tmdq_pkg::REQ_BITS-1:0]        s_req_type,
    input  logic [31:0]                          s_message_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tmdq_pkg::SHOWN_BITS-1:0]      m_shown_word,
    output logic                                 m_showing,
    output logic                                 m_unread,
    output logic [3:0]                           m_queued,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tmdq_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tmdq_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tmdq_pkg::*;

    logic                in_valid_reg;
    logic [REQ_BITS-1:0] in_req_reg;
    logic [31:0]         in_word_reg;
    logic                out_valid_reg;
    logic                step_en;
    tmdq_cfg_t           cfg_reg;
    tmdq_status_t        status;

    // Step when an item waits and the result slot is free or draining
    assign step_en   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_en;
    assign cfg_ready = 1'b1;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_req_reg  <= s_req_type;
            in_word_reg <= s_message_word;
        end
    end

    // Result beat valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.display_seconds  <= DISPLAY_SECONDS_RESET;
            cfg_reg.ticks_per_second <= TICKS_PER_SECOND_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DISPLAY_SECONDS:  cfg_reg.display_seconds  <= cfg_data[SEC_BITS-1:0];
                CFG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_data[SUB_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    tmdq_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .req_type     (in_req_reg),
        .message_word (in_word_reg),
        .cfg          (cfg_reg),
        .status       (status)
    );

    assign m_valid      = out_valid_reg;
    assign m_shown_word = status.shown_word;
    assign m_showing    = status.showing;
    assign m_unread     = status.unread;
    assign m_queued     = status.queued;

endmodule

### verif/timed_message_display_queue_unit_tb.sv
// Self-checking testbench for the timed message display queue unit.
`timescale 1ns / 100ps

import tmdq_pkg::*;

// Track queue and display state, keep the expected result beats in order, compare each one.
class display_queue_scoreboard;
    localparam int MAX_PRINTED = 40;

    logic [SHOWN_BITS-1:0] store [QUEUE_DEPTH];
    int                    wr_ptr;
    int                    rd_ptr;
    int                    fill;
    logic [SHOWN_BITS-1:0] slot;
    bit                    active;
    bit                    unread_mark;
    logic [SUB_BITS-1:0]   subticks;
    logic [SUB_BITS-1:0]   limit_subticks;
    logic [SEC_BITS-1:0]   seconds;
    logic [SEC_BITS-1:0]   limit_seconds;
    tmdq_status_t          expected_status [$];
    int unsigned           mismatches;

    function void reset_state();
        foreach (store[i]) store[i] = '0;
        wr_ptr         = 0;
        rd_ptr         = 0;
        fill           = 0;
        slot           = '0;
        active         = 1'b0;
        unread_mark    = 1'b0;
        subticks       = '0;
        seconds        = '0;
        limit_seconds  = DISPLAY_SECONDS_RESET;
        limit_subticks = TICKS_PER_SECOND_RESET;
        expected_status.delete();
        mismatches     = 0;
    endfunction

    function void set_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        if (idx == CFG_DISPLAY_SECONDS)
            limit_seconds = data[SEC_BITS-1:0];
        else
            limit_subticks = data[SUB_BITS-1:0];
    endfunction

    function int step_ptr(int p);
        return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    // Put a word on the display and restart the timeout.
    function void show_word(logic [SHOWN_BITS-1:0] w);
        active      = 1'b1;
        subticks    = '0;
        seconds     = '0;
        slot        = w;
        unread_mark = 1'b1;
    endfunction

    function tmdq_status_t predict_status(logic [REQ_BITS-1:0] req, logic [31:0] word);
        tmdq_status_t st;
        case (req)
            REQ_TICK: begin
                // Count sub-ticks only while something shows; clear once the seconds run out
                if (active) begin
                    subticks = subticks + 1'b1;
                    if (subticks > limit_subticks) begin
                        seconds = seconds + 1'b1;
                        if (seconds > limit_seconds) begin
                            seconds     = '0;
                            active      = 1'b0;
                            slot        = '0;
                            unread_mark = 1'b1;
                        end
                        subticks = '0;
                    end
                end
            end
            REQ_ENQUEUE: begin
                // A full queue pushes its oldest word straight onto the display
                if (fill == QUEUE_DEPTH) begin
                    show_word(store[rd_ptr]);
                    rd_ptr = step_ptr(rd_ptr);
                end else begin
                    fill++;
                end
                store[wr_ptr] = word;
                wr_ptr        = step_ptr(wr_ptr);
            end
            REQ_FORCE: show_word(word);
            REQ_ADVANCE: begin
                // Advance leaves the timer counters alone
                if (fill > 0 && !active) begin
                    slot        = store[rd_ptr];
                    rd_ptr      = step_ptr(rd_ptr);
                    unread_mark = 1'b1;
                    active      = 1'b1;
                    fill--;
                end
            end
            REQ_READ: unread_mark = 1'b0;
            default: ;
        endcase
        st.shown_word = slot;
        st.showing    = active;
        st.unread     = unread_mark;
        st.queued     = 4'(fill);
        return st;
    endfunction

    function void note_request(logic [REQ_BITS-1:0] req, logic [31:0] word);
        expected_status.push_back(predict_status(req, word));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, want);
    endtask

    task check_status(logic [SHOWN_BITS-1:0] shown, logic showing, logic unread_bit,
                      logic [3:0] queued);
        tmdq_status_t want;
        if (expected_status.size() == 0) begin
            report_mismatch("result beat with nothing pending", 32'(shown), '0);
            return;
        end
        want = expected_status.pop_front();
        if (shown !== want.shown_word)
            report_mismatch("shown_word", shown, want.shown_word);
        if (showing !== want.showing)
            report_mismatch("showing", 32'(showing), 32'(want.showing));
        if (unread_bit !== want.unread)
            report_mismatch("unread", 32'(unread_bit), 32'(want.unread));
        if (queued !== want.queued)
            report_mismatch("queued", 32'(queued), 32'(want.queued));
    endtask

    task report_leftover();
        if (expected_status.size() != 0)
            report_mismatch("result beats never delivered", expected_status.size(), '0);
    endtask
endclass

module timed_message_display_queue_unit_tb;

    localparam int RESET_CYCLES     = 10;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int TIMEOUT_NS       = 5_000_000;
    localparam int NUM_PHASES       = 7;
    localparam int HOLD_PHASE       = 1;
    localparam int PAUSE_PHASE      = 5;
    localparam int NUM_DIRECTED     = 24;

    // Request codes the block must ignore
    localparam logic [REQ_BITS-1:0] REQ_UNKNOWN_LO = 3'd5;
    localparam logic [REQ_BITS-1:0] REQ_UNKNOWN_HI = 3'd7;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic [REQ_BITS-1:0]      s_req_type     = '0;
    logic [31:0]              s_message_word = '0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic [SHOWN_BITS-1:0]    m_shown_word;
    logic                     m_showing;
    logic                     m_unread;
    logic [3:0]               m_queued;
    logic                     cfg_valid      = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data       = '0;

    display_queue_scoreboard sb;
    int src_idle_pct    = 20;
    int sink_idle_pct   = 20;
    bit long_hold_armed = 1'b0;

    timed_message_display_queue_unit u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_message_word (s_message_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_shown_word   (m_shown_word),
        .m_showing      (m_showing),
        .m_unread       (m_unread),
        .m_queued       (m_queued),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic void draw_request(output logic [REQ_BITS-1:0] req,
                                         output logic [31:0] word);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)      req = REQ_TICK;
        else if (roll < 62) req = REQ_ENQUEUE;
        else if (roll < 68) req = REQ_FORCE;
        else if (roll < 86) req = REQ_ADVANCE;
        else if (roll < 96) req = REQ_READ;
        else                req = 3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
        roll = $urandom_range(0, 15);
        if (roll == 0)      word = '0;
        else if (roll == 1) word = '1;
        else                word = $urandom;
    endfunction

    // Offer one input beat after a random gap and hold it until taken
    task automatic send_request(input logic [REQ_BITS-1:0] req, input logic [31:0] word);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_message_word <= word;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req, word);
    endtask

    // Stop offering and wait until every result beat is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.expected_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_register(idx, data);
        @(posedge aclk);
    endtask

    // Result sink: random stalls, plus one long hold on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_armed) begin
                long_hold_armed = 1'b0;
                stall_left      = LONG_HOLD_CYCLES;
            end else if (stall_left == 0) begin
                stall_left = pick_gap(sink_idle_pct);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Check every result beat taken on the m_ channel
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_status(m_shown_word, m_showing, m_unread, m_queued);
    end

    initial begin : stimulus
        logic [REQ_BITS-1:0] dir_req  [NUM_DIRECTED];
        logic [31:0]         dir_word [NUM_DIRECTED];
        logic [SEC_BITS-1:0] ph_seconds  [NUM_PHASES];
        logic [SUB_BITS-1:0] ph_subticks [NUM_PHASES];
        int                  ph_items    [NUM_PHASES];
        int                  ph_src_pct  [NUM_PHASES];
        int                  ph_sink_pct [NUM_PHASES];
        logic [REQ_BITS-1:0] req;
        logic [31:0]         word;

        // Empty queue and display, unknown codes, fill to full, eviction,
        // advance while showing, force of the empty word, timeouts, reads
        dir_req  = '{REQ_READ, REQ_TICK, REQ_ADVANCE, REQ_UNKNOWN_LO, REQ_UNKNOWN_LO + 3'd1,
                     REQ_UNKNOWN_HI, REQ_ENQUEUE, REQ_ENQUEUE, REQ_ENQUEUE, REQ_ENQUEUE,
                     REQ_ENQUEUE, REQ_ENQUEUE, REQ_ENQUEUE, REQ_ENQUEUE, REQ_ENQUEUE,
                     REQ_ADVANCE, REQ_TICK, REQ_READ, REQ_ADVANCE, REQ_FORCE, REQ_FORCE,
                     REQ_TICK, REQ_ADVANCE, REQ_READ};
        dir_word = '{32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF,
                     32'h0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
                     32'h8000_0000, 32'h1234_5678, 32'h9ABC_DEF0, 32'hDEAD_BEEF,
                     32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0};

        // Settings per phase; the wrapping limits never time out
        ph_seconds  = '{8'd0, 8'd2, 8'd255, 8'd254, 8'd3, 8'd1, 8'd6};
        ph_subticks = '{16'd0, 16'd1, 16'd3, 16'd65534, 16'd65535, 16'd2, 16'd4};
        ph_items    = '{300, 330, 200, 120, 120, 380, 300};
        ph_src_pct  = '{20, 0, 30, 20, 20, 30, 15};
        ph_sink_pct = '{20, 0, 30, 20, 20, 40, 25};

        sb = new;
        sb.reset_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats with a one-tick timeout
        write_register(CFG_TICKS_PER_SECOND, '0);
        write_register(CFG_DISPLAY_SECONDS, {8'($urandom), 8'd0});
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(dir_req[i], dir_word[i]);
        wait_drained();

        // Random phases, reconfigured while idle
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_register(CFG_DISPLAY_SECONDS, {8'($urandom), ph_seconds[p]});
            write_register(CFG_TICKS_PER_SECOND, ph_subticks[p]);
            src_idle_pct  = ph_src_pct[p];
            sink_idle_pct = ph_sink_pct[p];
            for (int i = 0; i < ph_items[p]; i++) begin
                if (p == HOLD_PHASE && i == 40)
                    long_hold_armed = 1'b1;
                if (p == PAUSE_PHASE && i == 150)
                    wait_drained();
                draw_request(req, word);
                send_request(req, word);
            end
            wait_drained();
        end

        repeat (4 * SETTLE_CYCLES) @(posedge aclk);
        sb.report_leftover();
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : watchdog
        #TIMEOUT_NS;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
hdl/tmdq_pkg.sv
hdl/tmdq_core.sv
hdl/timed_message_display_queue_unit.sv
verif/timed_message_display_queue_unit_tb.sv
